/* hdl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/cnbp_pkg.sv */
// Types, constants and helpers of the nearest non-empty bin picker.
package cnbp_pkg;

    localparam int MAX_BINS   = 16;
    localparam int COUNT_BITS = 16;
    localparam int BIN_W      = 4;
    localparam int SIZE_W     = 5;
    localparam int TOTAL_W    = 20;

    typedef logic [BIN_W-1:0]      bin_t;
    typedef logic [SIZE_W-1:0]     size_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [TOTAL_W-1:0]    total_t;

    localparam count_t COUNT_MAX = '1;
    localparam total_t TOTAL_MAX = '1;

    localparam logic FUNC_INSERT  = 1'b0;
    localparam logic FUNC_EXTRACT = 1'b1;

    // register select bit of paddr
    localparam logic REG_RING_SIZE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SEARCH
    } state_t;

    typedef struct packed {
        logic en;
        bin_t addr;
    } mem_rd_t;

    typedef struct packed {
        logic   en;
        bin_t   addr;
        count_t data;
    } mem_wr_t;

    function automatic bin_t ring_inc(input bin_t b, input size_t n);
        if (SIZE_W'(b) + SIZE_W'(1) == n) begin
            return '0;
        end
        return b + BIN_W'(1);
    endfunction

    function automatic bin_t ring_dec(input bin_t b, input size_t n);
        if (b == '0) begin
            return BIN_W'(n - SIZE_W'(1));
        end
        return b - BIN_W'(1);
    endfunction

    function automatic size_t size_sat(input size_t v);
        if (v == '0) begin
            return SIZE_W'(1);
        end
        if (v > SIZE_W'(MAX_BINS)) begin
            return SIZE_W'(MAX_BINS);
        end
        return v;
    endfunction

endpackage

/* hdl/cnbp_store.sv */
// Bin counter memory with per-entry valid bits and registered read data.
module cnbp_store (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  cnbp_pkg::mem_rd_t rd,
    input  cnbp_pkg::mem_wr_t wr,
    output cnbp_pkg::count_t  rdata
);
    import cnbp_pkg::*;

    count_t              mem [MAX_BINS];
    count_t              rdata_reg;
    logic [MAX_BINS-1:0] valid_reg;
    logic                rvalid_reg;
    bin_t                raddr_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rdata_reg <= mem[rd.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
            raddr_reg  <= '0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rvalid_reg <= valid_reg[rd.addr];
                raddr_reg  <= rd.addr;
            end
        end
    end

    // unwritten entries read as the cleared value: bin 0 one, rest zero
    assign rdata = rvalid_reg ? rdata_reg
                 : ((raddr_reg == '0) ? COUNT_BITS'(1) : '0);

endmodule

/* hdl/circular_nearest_nonempty_bin_picker_top.sv */
// Top level: token ring with pointer, nearest non-empty bin search.
// Insert: result on the done beat after the update state, next start accepted on the result cycle.
// Extract: takes from the pointer bin, then searches nearest-first with
// one counter memory read per cycle until a non-empty bin or the end.
// One item at a time; results come as a one-cycle done beat, never stalled.
// Reset: ring_size 1, bin 0 holds one token, pointer 0, total 1; no clear pass.
module circular_nearest_nonempty_bin_picker_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   start,
    output logic                   busy,
    input  logic                   func,
    input  cnbp_pkg::bin_t         bin_index,
    output logic                   done,
    output logic                   taken,
    output cnbp_pkg::bin_t         taken_bin,
    output cnbp_pkg::bin_t         pointer_now,
    output cnbp_pkg::total_t       total_tokens
);
    import cnbp_pkg::*;

`include "assert_macros.svh"

    state_t  state_reg, state_next;
    size_t   ring_size_reg, ring_size_next;
    bin_t    pointer_reg, pointer_next;
    total_t  total_reg, total_next;
    logic    func_reg, func_next;
    bin_t    idx_reg, idx_next;
    bin_t    fwd_reg, fwd_next;
    bin_t    bwd_reg, bwd_next;
    size_t   step_reg, step_next;
    logic    pend_reg, pend_next;
    bin_t    pend_addr_reg, pend_addr_next;
    logic    done_reg, done_next;
    logic    taken_reg, taken_next;
    bin_t    taken_bin_reg, taken_bin_next;

    mem_rd_t rd;
    mem_wr_t wr;
    count_t  rdata;
    logic    cfg_wr;
    size_t   cnt;
    bin_t    p_clamp;
    bin_t    cand;

    cnbp_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (cfg_wr),
        .rd    (rd),
        .wr    (wr),
        .rdata (rdata)
    );

    assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_RING_SIZE);
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_RING_SIZE) ? 32'(ring_size_reg) : '0;

    // candidates checked: forward and backward for each distance
    assign cnt     = {ring_size_reg[SIZE_W-1:1], 1'b0};
    assign p_clamp = (SIZE_W'(pointer_reg) < ring_size_reg) ? pointer_reg : '0;
    assign cand    = step_reg[0] ? bwd_reg : fwd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ring_size_reg <= SIZE_W'(1);
            pointer_reg   <= '0;
            total_reg     <= TOTAL_W'(1);
            func_reg      <= FUNC_INSERT;
            idx_reg       <= '0;
            fwd_reg       <= '0;
            bwd_reg       <= '0;
            step_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            done_reg      <= 1'b0;
            taken_reg     <= 1'b0;
            taken_bin_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ring_size_reg <= ring_size_next;
            pointer_reg   <= pointer_next;
            total_reg     <= total_next;
            func_reg      <= func_next;
            idx_reg       <= idx_next;
            fwd_reg       <= fwd_next;
            bwd_reg       <= bwd_next;
            step_reg      <= step_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            done_reg      <= done_next;
            taken_reg     <= taken_next;
            taken_bin_reg <= taken_bin_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ring_size_next = ring_size_reg;
        pointer_next   = pointer_reg;
        total_next     = total_reg;
        func_next      = func_reg;
        idx_next       = idx_reg;
        fwd_next       = fwd_reg;
        bwd_next       = bwd_reg;
        step_next      = step_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        done_next      = 1'b0;
        taken_next     = taken_reg;
        taken_bin_next = taken_bin_reg;
        rd             = '0;
        wr             = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next = func;
                    rd.en     = 1'b1;
                    if (func == FUNC_EXTRACT)
                    begin
                        idx_next = p_clamp;
                        rd.addr  = p_clamp;
                    end
                    else
                    begin
                        idx_next = bin_index;
                        rd.addr  = bin_index;
                    end
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                if (func_reg == FUNC_INSERT)
                begin
                    taken_next     = 1'b0;
                    taken_bin_next = '0;
                    if (SIZE_W'(idx_reg) < ring_size_reg && rdata != COUNT_MAX)
                    begin
                        wr.en   = 1'b1;
                        wr.addr = idx_reg;
                        wr.data = rdata + COUNT_BITS'(1);
                        if (total_reg != TOTAL_MAX)
                        begin
                            total_next = total_reg + TOTAL_W'(1);
                        end
                    end
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    pointer_next = idx_reg;
                    if (rdata != '0)
                    begin
                        wr.en          = 1'b1;
                        wr.addr        = idx_reg;
                        wr.data        = rdata - COUNT_BITS'(1);
                        taken_next     = 1'b1;
                        taken_bin_next = idx_reg;
                        if (total_reg != '0)
                        begin
                            total_next = total_reg - TOTAL_W'(1);
                        end
                    end
                    else
                    begin
                        taken_next     = 1'b0;
                        taken_bin_next = '0;
                    end
                    fwd_next  = ring_inc(idx_reg, ring_size_reg);
                    bwd_next  = ring_dec(idx_reg, ring_size_reg);
                    step_next = '0;
                    pend_next = 1'b0;
                    if (cnt == '0)
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH:
            begin
                // check the beat read last cycle, issue the next candidate
                if (pend_reg && rdata != '0)
                begin
                    pointer_next = pend_addr_reg;
                    pend_next    = 1'b0;
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (step_reg == cnt)
                begin
                    pend_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd.en          = 1'b1;
                    rd.addr        = cand;
                    pend_next      = 1'b1;
                    pend_addr_next = cand;
                    step_next      = step_reg + SIZE_W'(1);
                    if (step_reg[0])
                    begin
                        fwd_next = ring_inc(fwd_reg, ring_size_reg);
                        bwd_next = ring_dec(bwd_reg, ring_size_reg);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            ring_size_next = size_sat(pwdata[SIZE_W-1:0]);
            pointer_next   = '0;
            total_next     = TOTAL_W'(1);
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign taken        = taken_reg;
    assign taken_bin    = taken_bin_reg;
    assign pointer_now  = pointer_reg;
    assign total_tokens = total_reg;

    `ASSERT_ALWAYS(a_ptr_in_ring, clk, rst_n, SIZE_W'(pointer_reg) < ring_size_reg)
    `ASSERT_IMPL(a_done_after_work, clk, rst_n, done_reg, $past(state_reg != ST_IDLE))
    `ASSERT_IMPL(a_no_take_no_bin, clk, rst_n, done_reg && !taken_reg, taken_bin_reg == '0)
    `ASSERT_IMPL(a_step_bound, clk, rst_n, state_reg == ST_SEARCH, step_reg <= cnt)

endmodule
